/* hdl/bsl_pkg.sv */
// shared types, constants and command codes for the broadcast storm limiter
// no dependencies
package bsl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_RECV   = 3'd3;
  localparam logic [2:0] CMD_SEND   = 3'd4;
  localparam logic [2:0] CMD_BCAST  = 3'd5;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [1:0] REG_DEGRADE = 2'd0;
  localparam logic [1:0] REG_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PERCENT = 2'd2;
  localparam logic [1:0] REG_GAP     = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             tick_inc;
    logic             age;
    logic             find;
    logic             act;
    logic             bc_mul;
    logic             bc_dec;
    logic             emit_done;
    logic [IDX_W-1:0] idx;
  } bsl_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       not_addressed;
    logic       hit;
    logic       entry_valid;
    logic       empty;
    logic       more_after;
  } bsl_stat_t;

endpackage

/* hdl/broadcast_storm_limiter_core.sv */
// top level of the broadcast storm limiter: controller plus datapath
// depends on bsl_pkg, bsl_ctrl, bsl_dp

// An item is taken when start is high and busy is low. Each result shows for
// one cycle with result_valid high and cannot be held off; a broadcast request
// gives one result per valid entry in slot order, last marking the final one,
// or a single result when the table is empty. Tick, add, remove, receive and
// unicast send walk the table one slot per cycle through a single read port;
// a broadcast also steps over free slots one per cycle but spends a multiply
// step on each valid entry for its share test. Configuration writes are
// always ready and are to be made while idle; the block does not enforce it.
module broadcast_storm_limiter_core import bsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] interface_id,
  input  logic [15:0] byte_length,
  input  logic        bcast_dst,
  input  logic        for_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [31:0] out_interface,
  output logic        send,
  output logic        last
);

  bsl_ctrl_t ctrl;
  bsl_stat_t stat;

  assign cfg_ready = 1'b1;

  bsl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  bsl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .stat          (stat),
    .cmd           (cmd),
    .interface_id  (interface_id),
    .byte_length   (byte_length),
    .bcast_dst     (bcast_dst),
    .for_us        (for_us),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .status        (status),
    .out_interface (out_interface),
    .send          (send),
    .last          (last)
  );

endmodule

/* hdl/bsl_ctrl.sv */
// sequencer for the broadcast storm limiter: walks the table one slot a cycle,
// with a multiply step per valid broadcast entry; depends on bsl_pkg
module bsl_ctrl import bsl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  bsl_stat_t stat,
  output bsl_ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_ACT  = 3'd5;
  localparam logic [2:0] S_BMUL = 3'd6;
  localparam logic [2:0] S_BDEC = 3'd7;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             done_pending, done_pending_next;

  assign busy = (state != S_IDLE) || done_pending;

  // next state and commands
  always_comb begin
    state_next = state;
    idx_next = idx;
    done_pending_next = 1'b0;
    ctrl = '0;
    ctrl.idx = idx;
    ctrl.emit_done = done_pending;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          ctrl.load = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        idx_next = '0;
        case (stat.cmd)
          CMD_TICK: state_next = S_TICK;
          CMD_ADD, CMD_REMOVE, CMD_SEND: state_next = S_FIND;
          CMD_RECV: begin
            if (stat.not_addressed) begin
              state_next = S_IDLE;
              done_pending_next = 1'b1;
            end else begin
              state_next = S_FIND;
            end
          end
          CMD_BCAST: begin
            if (stat.empty) begin
              state_next = S_IDLE;
              done_pending_next = 1'b1;
            end else begin
              state_next = S_BMUL;
            end
          end
          default: begin
            state_next = S_IDLE;
            done_pending_next = 1'b1;
          end
        endcase
      end
      S_TICK: begin
        ctrl.tick_inc = 1'b1;
        state_next = S_AGE;
      end
      S_AGE: begin
        ctrl.age = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == IDX_LAST) begin
          state_next = S_IDLE;
          done_pending_next = 1'b1;
        end
      end
      S_FIND: begin
        ctrl.find = 1'b1;
        idx_next = idx + 1'b1;
        if (stat.hit || idx == IDX_LAST) state_next = S_ACT;
      end
      S_ACT: begin
        ctrl.act = 1'b1;
        state_next = S_IDLE;
        done_pending_next = 1'b1;
      end
      S_BMUL: begin
        if (stat.entry_valid) begin
          ctrl.bc_mul = 1'b1;
          state_next = S_BDEC;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_BDEC: begin
        ctrl.bc_dec = 1'b1;
        idx_next = idx + 1'b1;
        state_next = stat.more_after ? S_BMUL : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      done_pending <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      done_pending <= done_pending_next;
    end
  end

endmodule

/* hdl/bsl_dp.sv */
// datapath: interface table, clocks, configuration registers and result register
// depends on bsl_pkg
module bsl_dp import bsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bsl_ctrl_t   ctrl,
  output bsl_stat_t   stat,
  input  logic [2:0]  cmd,
  input  logic [31:0] interface_id,
  input  logic [15:0] byte_length,
  input  logic        bcast_dst,
  input  logic        for_us,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [31:0] out_interface,
  output logic        send,
  output logic        last
);

  // configuration
  logic [11:0] degrade_period;
  logic [19:0] entry_timeout;
  logic [6:0]  min_pct;
  logic [11:0] min_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      degrade_period <= 12'd10;
      entry_timeout <= 20'd86400;
      min_pct <= 7'd5;
      min_gap <= 12'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEGRADE: degrade_period <= cfg_data[11:0];
        REG_TIMEOUT: entry_timeout <= cfg_data;
        REG_PERCENT: min_pct <= cfg_data[6:0];
        REG_GAP:     min_gap <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic [2:0]  c_cmd;
  logic [31:0] c_if;
  logic [15:0] c_len;
  logic        c_bc;
  logic        c_us;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      c_cmd <= cmd;
      c_if <= interface_id;
      c_len <= byte_length;
      c_bc <= bcast_dst;
      c_us <= for_us;
    end
  end

  // table storage
  logic [TABLE_DEPTH-1:0] valid;
  logic [31:0] ent_if [TABLE_DEPTH];
  logic [15:0] rxb [TABLE_DEPTH];
  logic [15:0] rxu [TABLE_DEPTH];
  logic [15:0] txb [TABLE_DEPTH];
  logic [15:0] txu [TABLE_DEPTH];
  logic [31:0] lbt [TABLE_DEPTH];
  logic [31:0] lat [TABLE_DEPTH];
  logic [31:0] now;
  logic [31:0] last_degrade;
  logic        degrade;

  // search results
  logic             found, free_seen;
  logic [IDX_W-1:0] found_idx, free_idx;

  // multiply stage of the share test
  logic [24:0] prod;
  logic [22:0] lhs;

  logic [IDX_W-1:0] addr;
  logic [31:0] r_if, r_lbt, r_lat;
  logic [15:0] r_rxb, r_rxu, r_txb, r_txu;
  logic        r_valid;
  logic [15:0] units;
  logic        len_nz;
  logic [31:0] now_inc;
  logic [TABLE_DEPTH-1:0] after_mask;
  logic [16:0] denom;
  logic        share_ok, gap_ok, bsend;
  logic        have;
  logic [IDX_W-1:0] slot;

  assign slot = found ? found_idx : free_idx;
  assign have = found || free_seen;
  assign addr = ctrl.act ? slot : ctrl.idx;

  assign r_valid = valid[addr];
  assign r_if = ent_if[addr];
  assign r_rxb = rxb[addr];
  assign r_rxu = rxu[addr];
  assign r_txb = txb[addr];
  assign r_txu = txu[addr];
  assign r_lbt = lbt[addr];
  assign r_lat = lat[addr];

  assign units = 16'd1 + {7'd0, c_len[15:9]};
  assign len_nz = (c_len != 16'd0);
  assign now_inc = now + 32'd1;
  assign after_mask = ~((TABLE_DEPTH'(2) << ctrl.idx) - TABLE_DEPTH'(1));
  assign denom = 17'd1 + {1'b0, r_rxb} + {1'b0, r_rxu};
  assign share_ok = ({2'b0, lhs} < prod);
  assign gap_ok = ((now - r_lbt) > {20'd0, min_gap});
  assign bsend = share_ok || gap_ok;

  // status to controller
  always_comb begin
    stat.cmd = c_cmd;
    stat.not_addressed = !c_bc && !c_us;
    stat.hit = r_valid && (r_if == c_if);
    stat.entry_valid = r_valid;
    stat.empty = (valid == '0);
    stat.more_after = |(valid & after_mask);
  end

  // clock and degrade bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
      last_degrade <= '0;
      degrade <= 1'b0;
    end else if (ctrl.tick_inc) begin
      now <= now_inc;
      degrade <= (now_inc - last_degrade) > {20'd0, degrade_period};
      if ((now_inc - last_degrade) > {20'd0, degrade_period}) last_degrade <= now_inc;
    end
  end

  // share test operands
  always_ff @(posedge clk) begin
    if (ctrl.bc_mul) begin
      prod <= ({18'd0, min_pct} + 25'd1) * {8'd0, denom};
      lhs <= 23'd100 * ({7'd0, r_rxb} + 23'd1);
    end
  end

  // search tracking
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      found <= 1'b0;
      free_seen <= 1'b0;
    end else if (ctrl.find) begin
      if (stat.hit) begin
        found <= 1'b1;
        found_idx <= ctrl.idx;
      end
      if (!r_valid && !free_seen) begin
        free_seen <= 1'b1;
        free_idx <= ctrl.idx;
      end
    end
  end

  // table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.age) begin
      if (r_valid) begin
        if ((now - r_lat) > {12'd0, entry_timeout}) begin
          valid[addr] <= 1'b0;
        end else if (degrade) begin
          rxb[addr] <= r_rxb >> 1;
          rxu[addr] <= r_rxu >> 1;
          txb[addr] <= r_txb >> 1;
          txu[addr] <= r_txu >> 1;
        end
      end
    end else if (ctrl.act) begin
      if (c_cmd == CMD_REMOVE) begin
        if (found) valid[addr] <= 1'b0;
      end else if (!found && free_seen) begin
        // new entry, with the packet folded in
        valid[addr] <= 1'b1;
        ent_if[addr] <= c_if;
        lbt[addr] <= '0;
        lat[addr] <= now;
        txb[addr] <= '0;
        rxb[addr] <= (c_cmd == CMD_RECV && c_bc && len_nz) ? units : 16'd0;
        rxu[addr] <= (c_cmd == CMD_RECV && !c_bc && len_nz) ? units : 16'd0;
        txu[addr] <= (c_cmd == CMD_SEND && len_nz) ? units : 16'd0;
      end else if (found && len_nz) begin
        if (c_cmd == CMD_RECV) begin
          if (c_bc) rxb[addr] <= r_rxb + units;
          else rxu[addr] <= r_rxu + units;
          lat[addr] <= now;
        end else if (c_cmd == CMD_SEND) begin
          txu[addr] <= r_txu + units;
          lat[addr] <= now;
        end
      end
    end else if (ctrl.bc_dec) begin
      if (bsend && len_nz) begin
        txb[addr] <= r_txb + units;
        lat[addr] <= now;
        lbt[addr] <= now;
      end
    end
  end

  // status of the finishing command
  logic [1:0] st_code;
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      st_code <= (cmd == CMD_RECV && !bcast_dst && !for_us) ? ST_IGNORED : ST_DONE;
    end else if (ctrl.act && c_cmd != CMD_REMOVE && !have) begin
      st_code <= ST_FULL;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit_done || ctrl.bc_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bc_dec) begin
      status <= ST_DONE;
      out_interface <= r_if;
      send <= bsend;
      last <= !stat.more_after;
    end else if (ctrl.emit_done) begin
      status <= st_code;
      out_interface <= '0;
      send <= (c_cmd == CMD_BCAST);
      last <= 1'b1;
    end
  end

endmodule

/* bench/broadcast_storm_limiter_checker.sv */
// checker for the broadcast storm limiter: tracks item and config transfers,
// predicts the results of each item and compares them; depends on bsl_pkg
`timescale 1ns / 100ps

module broadcast_storm_limiter_checker import bsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] interface_id,
  input  logic [15:0] byte_length,
  input  logic        bcast_dst,
  input  logic        for_us,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  input  logic        result_valid,
  input  logic [1:0]  status,
  input  logic [31:0] out_interface,
  input  logic        send,
  input  logic        last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] ifc;
    logic        send;
    logic        last;
  } decision_t;

  decision_t expected_q[$];

  // shadow of the limiter state
  logic [11:0] degrade_period;
  logic [19:0] entry_timeout;
  logic [6:0]  min_percent;
  logic [11:0] min_gap;
  logic        valid_tab [TABLE_DEPTH];
  logic [31:0] ifc_tab   [TABLE_DEPTH];
  logic [15:0] rx_bc     [TABLE_DEPTH];
  logic [15:0] rx_uc     [TABLE_DEPTH];
  logic [15:0] tx_bc     [TABLE_DEPTH];
  logic [15:0] tx_uc     [TABLE_DEPTH];
  logic [31:0] last_bc_t [TABLE_DEPTH];
  logic [31:0] last_act_t[TABLE_DEPTH];
  logic [31:0] now_s;
  logic [31:0] last_degrade;

  function automatic int lookup_entry(logic [31:0] ifc);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (valid_tab[i] && ifc_tab[i] == ifc) return i;
    return -1;
  endfunction

  // find or allocate lowest free slot; -1 when full
  function automatic int claim_entry(logic [31:0] ifc);
    int s;
    s = lookup_entry(ifc);
    if (s >= 0) return s;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (!valid_tab[i]) begin
        valid_tab[i] = 1'b1;
        ifc_tab[i] = ifc;
        rx_bc[i] = '0; rx_uc[i] = '0; tx_bc[i] = '0; tx_uc[i] = '0;
        last_bc_t[i] = '0;
        last_act_t[i] = now_s;
        return i;
      end
    return -1;
  endfunction

  function automatic logic [15:0] units(logic [15:0] len);
    return 16'd1 + (len >> 9);
  endfunction

  task automatic push_done(logic [1:0] st);
    expected_q.push_back('{status: st, ifc: 32'd0, send: 1'b0, last: 1'b1});
  endtask

  // predict the decisions caused by one item
  task automatic predict_limiter(logic [2:0] c, logic [31:0] ifc, logic [15:0] len,
                                 logic bc, logic fu);
    int s;
    int total;
    int n;
    logic degrade;
    logic [31:0] pc;
    logic ok;
    case (c)
      CMD_TICK: begin
        now_s = now_s + 1;
        degrade = (now_s - last_degrade) > {20'd0, degrade_period};
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!valid_tab[i]) continue;
          if ((now_s - last_act_t[i]) > {12'd0, entry_timeout}) valid_tab[i] = 1'b0;
          else if (degrade) begin
            rx_bc[i] = rx_bc[i] >> 1; rx_uc[i] = rx_uc[i] >> 1;
            tx_bc[i] = tx_bc[i] >> 1; tx_uc[i] = tx_uc[i] >> 1;
          end
        end
        if (degrade) last_degrade = now_s;
        push_done(ST_DONE);
      end
      CMD_ADD: push_done(claim_entry(ifc) < 0 ? ST_FULL : ST_DONE);
      CMD_REMOVE: begin
        s = lookup_entry(ifc);
        if (s >= 0) valid_tab[s] = 1'b0;
        push_done(ST_DONE);
      end
      CMD_RECV: begin
        if (!bc && !fu) push_done(ST_IGNORED);
        else begin
          s = claim_entry(ifc);
          if (s < 0) push_done(ST_FULL);
          else begin
            if (len > 0) begin
              if (bc) rx_bc[s] = rx_bc[s] + units(len);
              else rx_uc[s] = rx_uc[s] + units(len);
              last_act_t[s] = now_s;
            end
            push_done(ST_DONE);
          end
        end
      end
      CMD_SEND: begin
        s = claim_entry(ifc);
        if (s < 0) push_done(ST_FULL);
        else begin
          if (len > 0) begin
            tx_uc[s] = tx_uc[s] + units(len);
            last_act_t[s] = now_s;
          end
          push_done(ST_DONE);
        end
      end
      CMD_BCAST: begin
        total = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) if (valid_tab[i]) total++;
        if (total == 0)
          expected_q.push_back('{status: ST_DONE, ifc: 32'd0, send: 1'b1, last: 1'b1});
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!valid_tab[i]) continue;
          pc = (32'd100 * (32'd1 + rx_bc[i])) / (32'd1 + rx_bc[i] + rx_uc[i]);
          ok = (pc <= {25'd0, min_percent}) || ((now_s - last_bc_t[i]) > {20'd0, min_gap});
          if (ok && len > 0) begin
            tx_bc[i] = tx_bc[i] + units(len);
            last_act_t[i] = now_s;
            last_bc_t[i] = now_s;
          end
          n++;
          expected_q.push_back('{status: ST_DONE, ifc: ifc_tab[i], send: ok,
                                 last: (n == total)});
        end
      end
      default: push_done(ST_DONE);
    endcase
  endtask

  // track transfers and compare results
  always @(posedge clk) begin
    decision_t got, want;
    if (rst) begin
      degrade_period = 12'd10;
      entry_timeout = 20'd86400;
      min_percent = 7'd5;
      min_gap = 12'd1;
      now_s = '0;
      last_degrade = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) valid_tab[i] = 1'b0;
      expected_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (result_valid) begin
        got = '{status: status, ifc: out_interface, send: send, last: last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status || got.ifc !== want.ifc ||
              got.send !== want.send || got.last !== want.last) begin
            $display("%0t: mismatch expected %0d/%h/%b/%b, actual %0d/%h/%b/%b",
                     $time, want.status, want.ifc, want.send, want.last,
                     got.status, got.ifc, got.send, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        case (cfg_index)
          REG_DEGRADE: degrade_period = cfg_data[11:0];
          REG_TIMEOUT: entry_timeout = cfg_data;
          REG_PERCENT: min_percent = cfg_data[6:0];
          REG_GAP:     min_gap = cfg_data[11:0];
          default: ;
        endcase
      if (start && !busy)
        predict_limiter(cmd, interface_id, byte_length, bcast_dst, for_us);
      pending_count <= expected_q.size();
    end
  end

endmodule

/* bench/broadcast_storm_limiter_core_tb.sv */
// top of the broadcast storm limiter bench: clock, reset, stimulus and verdict
// depends on bsl_pkg, broadcast_storm_limiter_core, broadcast_storm_limiter_checker
`timescale 1ns / 100ps

module broadcast_storm_limiter_core_tb;
  import bsl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  cmd = '0;
  logic [31:0] interface_id = '0;
  logic [15:0] byte_length = '0;
  logic        bcast_dst = 1'b0;
  logic        for_us = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic        result_valid;
  logic [1:0]  status;
  logic [31:0] out_interface;
  logic        send;
  logic        last;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          idle_pct = 0;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 80;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  broadcast_storm_limiter_core u_dut (.*);

  broadcast_storm_limiter_checker u_check (.*);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // small pool of interfaces so entries get reused, with extreme ids in it
  function automatic logic [31:0] pick_ifc();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // one item transfer, optionally preceded by random idle cycles;
  // start is left high so the next item can follow with no gap
  task automatic issue_item(logic [2:0] c, logic [31:0] ifc, logic [15:0] len,
                            logic bc, logic fu);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c; interface_id <= ifc; byte_length <= len;
    bcast_dst <= bc; for_us <= fu;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // valid is left high for back to back writes
  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic random_item();
    logic [2:0]  c;
    logic [15:0] len;
    c = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) len = 16'($urandom);
    else len = 16'($urandom_range(0, 1500));
    issue_item(c, pick_ifc(), len, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, every command, full table
    issue_item(CMD_BCAST, 32'd7, 16'd100, 1'b0, 1'b0);
    issue_item(CMD_RECV, 32'd1, 16'd10, 1'b0, 1'b0);
    issue_item(CMD_RECV, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    issue_item(CMD_RECV, 32'd2, 16'd0, 1'b0, 1'b1);
    issue_item(CMD_SEND, 32'd3, 16'd512, 1'b0, 1'b0);
    issue_item(CMD_ADD, 32'd1, 16'd0, 1'b0, 1'b0);
    issue_item(CMD_REMOVE, 32'd99, 16'd0, 1'b0, 1'b0);
    issue_item(CMD_BCAST, 32'd0, 16'd1, 1'b0, 1'b0);
    issue_item(CMD_TICK, 32'd0, 16'd0, 1'b0, 1'b0);
    issue_item(CMD_TICK, 32'd0, 16'd0, 1'b0, 1'b0);
    issue_item(CMD_BCAST, 32'd0, 16'd0, 1'b0, 1'b0);
    issue_item(3'd6, 32'd5, 16'd5, 1'b1, 1'b1);
    issue_item(3'd7, 32'd5, 16'd5, 1'b1, 1'b1);
    for (int i = 0; i < 14; i++)
      issue_item(CMD_ADD, 32'd100 + i, 16'd0, 1'b0, 1'b0);
    issue_item(CMD_RECV, 32'd500, 16'd64, 1'b1, 1'b0);
    issue_item(CMD_SEND, 32'd501, 16'd64, 1'b0, 1'b0);
    issue_item(CMD_BCAST, 32'd0, 16'd700, 1'b0, 1'b0);
    issue_item(CMD_REMOVE, 32'd1, 16'd0, 1'b0, 1'b0);
    drain_results();

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DEGRADE, 20'd1); write_reg(REG_TIMEOUT, 20'd1);
          write_reg(REG_PERCENT, 20'd0); write_reg(REG_GAP, 20'd0);
        end
        1: begin
          write_reg(REG_DEGRADE, 20'd3600); write_reg(REG_TIMEOUT, 20'd1000000);
          write_reg(REG_PERCENT, 20'd100); write_reg(REG_GAP, 20'd3600);
        end
        5: begin
          write_reg(REG_DEGRADE, 20'hFFFFF); write_reg(REG_TIMEOUT, 20'hFFFFF);
          write_reg(REG_PERCENT, 20'hFFFFF); write_reg(REG_GAP, 20'hFFFFF);
        end
        default: begin
          write_reg(REG_DEGRADE, 20'($urandom_range(1, 8)));
          write_reg(REG_TIMEOUT, 20'($urandom_range(2, 12)));
          write_reg(REG_PERCENT, 20'($urandom_range(0, 100)));
          write_reg(REG_GAP, 20'($urandom_range(0, 4)));
        end
      endcase
      cfg_valid <= 1'b0;
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 53;
        2: idle_pct = 53;
        default: idle_pct = 17;
      endcase
      for (int k = 0; k < 23; k++) random_item();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/bsl_pkg.sv
hdl/bsl_ctrl.sv
hdl/bsl_dp.sv
hdl/broadcast_storm_limiter_core.sv
bench/broadcast_storm_limiter_checker.sv
bench/broadcast_storm_limiter_core_tb.sv
